@@ sv/bcfl_pkg.sv @@
`timescale 1ns / 1ps

package bcfl_pkg;

  localparam int BLOCK_COUNT_DEF = 256;
  localparam int FIRST_FREE      = 2;

  localparam int FUNC_W   = 3;
  localparam int BLOCK_W  = 8;
  localparam int NEED_W   = 9;
  localparam int STATUS_W = 2;

  localparam logic [FUNC_W-1:0] FN_FORMAT     = 3'd0;
  localparam logic [FUNC_W-1:0] FN_ALLOCATE   = 3'd1;
  localparam logic [FUNC_W-1:0] FN_FIND_LAST  = 3'd2;
  localparam logic [FUNC_W-1:0] FN_FREE_CHAIN = 3'd3;
  localparam logic [FUNC_W-1:0] FN_NEXT_OF    = 3'd4;
  localparam logic [FUNC_W-1:0] FN_COUNT_FREE = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOSPACE  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_CHAINERR = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_FMT,
    S_ALLOC_RD,
    S_ALLOC_WR,
    S_ALLOC_LINK,
    S_WALK_RD,
    S_WALK_CHK,
    S_FREE_LINK,
    S_NEXT_RD,
    S_NEXT_DONE,
    S_CNT_CHK,
    S_CNT_NXT
  } state_t;

  typedef enum logic [2:0] {
    CUR_HOLD,
    CUR_ZERO,
    CUR_BLK,
    CUR_HEAD,
    CUR_RDATA,
    CUR_INC
  } cur_sel_t;

  typedef enum logic [1:0] {
    HEAD_HOLD,
    HEAD_FMT,
    HEAD_RDATA,
    HEAD_BLK
  } head_sel_t;

  typedef enum logic {
    WA_CUR,
    WA_BLK
  } waddr_sel_t;

  typedef enum logic [1:0] {
    WD_FMT,
    WD_ZERO,
    WD_CUR,
    WD_HEAD
  } wdata_sel_t;

  typedef enum logic [1:0] {
    RES_ZERO,
    RES_CUR,
    RES_RDATA
  } res_sel_t;

  typedef struct packed {
    logic                capture;
    cur_sel_t            cur_sel;
    logic                steps_clr;
    logic                steps_inc;
    logic                found_clr;
    logic                found_inc;
    logic                rd_en;
    logic                wr_en;
    waddr_sel_t          waddr_sel;
    wdata_sel_t          wdata_sel;
    head_sel_t           head_sel;
    logic                out_en;
    res_sel_t            res_sel;
    logic                out_found;
    logic [STATUS_W-1:0] out_status;
  } cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] op;
    logic              blk_ok;
    logic              head_ok;
    logic              link_zero;
    logic              steps_max;
    logic              cnt_more;
    logic              found_max;
    logic              found_short;
    logic              fmt_end;
  } stat_t;

endpackage

@@ sv/bcfl_dpath.sv @@
`timescale 1ns / 1ps

module bcfl_dpath #(
  parameter int BLOCK_COUNT = bcfl_pkg::BLOCK_COUNT_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [bcfl_pkg::FUNC_W-1:0]       func,
  input  logic [bcfl_pkg::BLOCK_W-1:0]      block,
  input  logic [bcfl_pkg::NEED_W-1:0]       need,
  input  bcfl_pkg::cmd_t                    cmd,
  output bcfl_pkg::stat_t                   stat,
  output logic                              done,
  output logic [bcfl_pkg::BLOCK_W-1:0]      result_block,
  output logic [bcfl_pkg::NEED_W-1:0]       free_found,
  output logic [bcfl_pkg::STATUS_W-1:0]     status
);

  localparam int AW = $clog2(BLOCK_COUNT);
  localparam int SW = AW + 1;
  localparam int XW = (SW > bcfl_pkg::BLOCK_W) ? SW : bcfl_pkg::BLOCK_W;
  localparam int CW = (SW > bcfl_pkg::NEED_W) ? SW : bcfl_pkg::NEED_W;
  localparam logic [AW-1:0] LAST_BLK   = AW'(BLOCK_COUNT - 1);
  localparam logic [AW-1:0] FIRST_BLK  = AW'(bcfl_pkg::FIRST_FREE);
  localparam logic [XW-1:0] FIRST_BLKX = XW'(bcfl_pkg::FIRST_FREE);
  localparam logic [XW-1:0] COUNT_X    = XW'(BLOCK_COUNT);
  localparam logic [SW-1:0] COUNT_S    = SW'(BLOCK_COUNT);
  localparam logic [CW-1:0] COUNT_C    = CW'(BLOCK_COUNT);

  logic [AW-1:0] mem [BLOCK_COUNT];
  logic [AW-1:0] rdata;

  logic [bcfl_pkg::FUNC_W-1:0]  op;
  logic [bcfl_pkg::BLOCK_W-1:0] blk;
  logic [bcfl_pkg::NEED_W-1:0]  need_q;
  logic [AW-1:0]                cur;
  logic [AW-1:0]                cur_next;
  logic [AW-1:0]                free_head;
  logic [AW-1:0]                free_head_next;
  logic [SW-1:0]                steps;
  logic [bcfl_pkg::NEED_W-1:0]  found;

  logic [XW-1:0] blk_x;
  logic [AW-1:0] blk_a;
  logic [AW-1:0] waddr;
  logic [AW-1:0] wdata;
  logic [AW-1:0] fmt_val;
  logic [AW-1:0] res_a;
  logic [XW-1:0] res_x;

  assign blk_x   = XW'(blk);
  assign blk_a   = blk_x[AW-1:0];
  assign fmt_val = (cur < FIRST_BLK || cur == LAST_BLK) ? '0 : cur + 1'b1;

  always_comb begin
    case (cmd.cur_sel)
      bcfl_pkg::CUR_ZERO:  cur_next = '0;
      bcfl_pkg::CUR_BLK:   cur_next = blk_a;
      bcfl_pkg::CUR_HEAD:  cur_next = free_head;
      bcfl_pkg::CUR_RDATA: cur_next = rdata;
      bcfl_pkg::CUR_INC:   cur_next = cur + 1'b1;
      default:             cur_next = cur;
    endcase
  end

  always_comb begin
    case (cmd.head_sel)
      bcfl_pkg::HEAD_FMT:   free_head_next = FIRST_BLK;
      bcfl_pkg::HEAD_RDATA: free_head_next = rdata;
      bcfl_pkg::HEAD_BLK:   free_head_next = blk_a;
      default:              free_head_next = free_head;
    endcase
  end

  always_comb begin
    waddr = (cmd.waddr_sel == bcfl_pkg::WA_BLK) ? blk_a : cur;
    case (cmd.wdata_sel)
      bcfl_pkg::WD_FMT:  wdata = fmt_val;
      bcfl_pkg::WD_CUR:  wdata = cur;
      bcfl_pkg::WD_HEAD: wdata = free_head;
      default:           wdata = '0;
    endcase
  end

  always_comb begin
    case (cmd.res_sel)
      bcfl_pkg::RES_CUR:   res_a = cur;
      bcfl_pkg::RES_RDATA: res_a = rdata;
      default:             res_a = '0;
    endcase
    res_x = XW'(res_a);
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[waddr] <= wdata;
    end
    if (cmd.rd_en) begin
      rdata <= mem[cur];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op     <= func;
      blk    <= block;
      need_q <= need;
    end
    cur <= cur_next;
    if (cmd.steps_clr) begin
      steps <= '0;
    end else if (cmd.steps_inc) begin
      steps <= steps + 1'b1;
    end
    if (cmd.found_clr) begin
      found <= '0;
    end else if (cmd.found_inc) begin
      found <= found + 1'b1;
    end
    if (cmd.out_en) begin
      result_block <= res_x[bcfl_pkg::BLOCK_W-1:0];
      free_found   <= cmd.out_found ? found : '0;
      status       <= cmd.out_status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free_head <= '0;
      done      <= 1'b0;
    end else begin
      free_head <= free_head_next;
      done      <= cmd.out_en;
    end
  end

  always_comb begin
    stat.op          = op;
    stat.blk_ok      = (blk_x >= FIRST_BLKX) && (blk_x < COUNT_X);
    stat.head_ok     = (free_head >= FIRST_BLK);
    stat.link_zero   = (rdata == '0);
    stat.steps_max   = (steps >= COUNT_S);
    stat.cnt_more    = (found < need_q) && (cur != '0);
    stat.found_max   = (CW'(found) >= COUNT_C);
    stat.found_short = (found < need_q);
    stat.fmt_end     = (cur == LAST_BLK);
  end

endmodule

@@ sv/bcfl_ctrl.sv @@
`timescale 1ns / 1ps

module bcfl_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  bcfl_pkg::stat_t stat,
  output bcfl_pkg::cmd_t  cmd,
  output logic            busy
);

  bcfl_pkg::state_t state;
  bcfl_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bcfl_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != bcfl_pkg::S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      bcfl_pkg::S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_next  = bcfl_pkg::S_DISPATCH;
        end
      end

      bcfl_pkg::S_DISPATCH: begin
        case (stat.op)
          bcfl_pkg::FN_FORMAT: begin
            cmd.cur_sel = bcfl_pkg::CUR_ZERO;
            state_next  = bcfl_pkg::S_FMT;
          end
          bcfl_pkg::FN_ALLOCATE: begin
            if (stat.head_ok) begin
              cmd.cur_sel = bcfl_pkg::CUR_HEAD;
              state_next  = bcfl_pkg::S_ALLOC_RD;
            end else begin
              cmd.out_en     = 1'b1;
              cmd.out_status = bcfl_pkg::ST_NOSPACE;
              state_next     = bcfl_pkg::S_IDLE;
            end
          end
          bcfl_pkg::FN_FIND_LAST, bcfl_pkg::FN_FREE_CHAIN: begin
            if (stat.blk_ok) begin
              cmd.cur_sel   = bcfl_pkg::CUR_BLK;
              cmd.steps_clr = 1'b1;
              state_next    = bcfl_pkg::S_WALK_RD;
            end else begin
              cmd.out_en = 1'b1;
              state_next = bcfl_pkg::S_IDLE;
            end
          end
          bcfl_pkg::FN_NEXT_OF: begin
            if (stat.blk_ok) begin
              cmd.cur_sel = bcfl_pkg::CUR_BLK;
              state_next  = bcfl_pkg::S_NEXT_RD;
            end else begin
              cmd.out_en = 1'b1;
              state_next = bcfl_pkg::S_IDLE;
            end
          end
          bcfl_pkg::FN_COUNT_FREE: begin
            cmd.cur_sel   = bcfl_pkg::CUR_HEAD;
            cmd.found_clr = 1'b1;
            state_next    = bcfl_pkg::S_CNT_CHK;
          end
          default: begin
            cmd.out_en = 1'b1;
            state_next = bcfl_pkg::S_IDLE;
          end
        endcase
      end

      bcfl_pkg::S_FMT: begin
        cmd.wr_en     = 1'b1;
        cmd.wdata_sel = bcfl_pkg::WD_FMT;
        if (stat.fmt_end) begin
          cmd.head_sel = bcfl_pkg::HEAD_FMT;
          cmd.out_en   = 1'b1;
          state_next   = bcfl_pkg::S_IDLE;
        end else begin
          cmd.cur_sel = bcfl_pkg::CUR_INC;
        end
      end

      bcfl_pkg::S_ALLOC_RD: begin
        cmd.rd_en  = 1'b1;
        state_next = bcfl_pkg::S_ALLOC_WR;
      end

      bcfl_pkg::S_ALLOC_WR: begin
        cmd.head_sel  = bcfl_pkg::HEAD_RDATA;
        cmd.wr_en     = 1'b1;
        cmd.wdata_sel = bcfl_pkg::WD_ZERO;
        if (stat.blk_ok) begin
          state_next = bcfl_pkg::S_ALLOC_LINK;
        end else begin
          cmd.out_en  = 1'b1;
          cmd.res_sel = bcfl_pkg::RES_CUR;
          state_next  = bcfl_pkg::S_IDLE;
        end
      end

      bcfl_pkg::S_ALLOC_LINK: begin
        cmd.wr_en     = 1'b1;
        cmd.waddr_sel = bcfl_pkg::WA_BLK;
        cmd.wdata_sel = bcfl_pkg::WD_CUR;
        cmd.out_en    = 1'b1;
        cmd.res_sel   = bcfl_pkg::RES_CUR;
        state_next    = bcfl_pkg::S_IDLE;
      end

      bcfl_pkg::S_WALK_RD: begin
        cmd.rd_en  = 1'b1;
        state_next = bcfl_pkg::S_WALK_CHK;
      end

      bcfl_pkg::S_WALK_CHK: begin
        if (stat.link_zero) begin
          if (stat.op == bcfl_pkg::FN_FREE_CHAIN) begin
            state_next = bcfl_pkg::S_FREE_LINK;
          end else begin
            cmd.out_en  = 1'b1;
            cmd.res_sel = bcfl_pkg::RES_CUR;
            state_next  = bcfl_pkg::S_IDLE;
          end
        end else if (stat.steps_max) begin
          cmd.out_en     = 1'b1;
          cmd.out_status = bcfl_pkg::ST_CHAINERR;
          state_next     = bcfl_pkg::S_IDLE;
        end else begin
          cmd.cur_sel   = bcfl_pkg::CUR_RDATA;
          cmd.steps_inc = 1'b1;
          state_next    = bcfl_pkg::S_WALK_RD;
        end
      end

      bcfl_pkg::S_FREE_LINK: begin
        cmd.wr_en     = 1'b1;
        cmd.wdata_sel = bcfl_pkg::WD_HEAD;
        cmd.head_sel  = bcfl_pkg::HEAD_BLK;
        cmd.out_en    = 1'b1;
        state_next    = bcfl_pkg::S_IDLE;
      end

      bcfl_pkg::S_NEXT_RD: begin
        cmd.rd_en  = 1'b1;
        state_next = bcfl_pkg::S_NEXT_DONE;
      end

      bcfl_pkg::S_NEXT_DONE: begin
        cmd.out_en  = 1'b1;
        cmd.res_sel = bcfl_pkg::RES_RDATA;
        state_next  = bcfl_pkg::S_IDLE;
      end

      bcfl_pkg::S_CNT_CHK: begin
        if (stat.cnt_more) begin
          if (stat.found_max) begin
            cmd.out_en     = 1'b1;
            cmd.out_status = bcfl_pkg::ST_CHAINERR;
            state_next     = bcfl_pkg::S_IDLE;
          end else begin
            cmd.found_inc = 1'b1;
            cmd.rd_en     = 1'b1;
            state_next    = bcfl_pkg::S_CNT_NXT;
          end
        end else begin
          cmd.out_en     = 1'b1;
          cmd.out_found  = 1'b1;
          cmd.out_status = stat.found_short ? bcfl_pkg::ST_NOSPACE : bcfl_pkg::ST_OK;
          state_next     = bcfl_pkg::S_IDLE;
        end
      end

      bcfl_pkg::S_CNT_NXT: begin
        cmd.cur_sel = bcfl_pkg::CUR_RDATA;
        state_next  = bcfl_pkg::S_CNT_CHK;
      end

      default: begin
        state_next = bcfl_pkg::S_IDLE;
      end
    endcase
  end

endmodule

@@ sv/block_chain_free_list_manager.sv @@
`timescale 1ns / 1ps

// Channel   Handshake             Payload
// -------   --------------------  ----------------------------------
// command   start, busy           func, block, need
// result    done (one-cycle)      result_block, free_found, status
//
// One transaction at a time; busy drops as the result is registered, so a new command
// can be accepted in the cycle where done is high.
// Each transaction steps through the next-block table one entry at a time: format writes
//   every entry, find_last, free_chain and count_free follow links, allocate and next_of
//   read one link; an unusable block, an empty list on allocate or a spare code ends at dispatch.
// Synchronous reset empties the free list; table contents stay unknown until format.
// The receiver cannot stall: done is high for exactly one cycle per result.

module block_chain_free_list_manager #(
  parameter int BLOCK_COUNT = bcfl_pkg::BLOCK_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [bcfl_pkg::FUNC_W-1:0]   func,
  input  logic [bcfl_pkg::BLOCK_W-1:0]  block,
  input  logic [bcfl_pkg::NEED_W-1:0]   need,
  output logic                          done,
  output logic [bcfl_pkg::BLOCK_W-1:0]  result_block,
  output logic [bcfl_pkg::NEED_W-1:0]   free_found,
  output logic [bcfl_pkg::STATUS_W-1:0] status
);

  bcfl_pkg::cmd_t  cmd;
  bcfl_pkg::stat_t stat;

  bcfl_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  bcfl_dpath #(
    .BLOCK_COUNT (BLOCK_COUNT)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .func         (func),
    .block        (block),
    .need         (need),
    .cmd          (cmd),
    .stat         (stat),
    .done         (done),
    .result_block (result_block),
    .free_found   (free_found),
    .status       (status)
  );

endmodule
